// File: design/sic_pkg.sv
`timescale 1ns / 1ps

package sic_pkg;

  // Relation codes of a result beat.
  localparam logic [2:0] REL_COLLINEAR = 3'd0;
  localparam logic [2:0] REL_PARALLEL  = 3'd1;
  localparam logic [2:0] REL_CROSS     = 3'd2;
  localparam logic [2:0] REL_FIRST     = 3'd3;
  localparam logic [2:0] REL_SECOND    = 3'd4;
  localparam logic [2:0] REL_LINES     = 3'd5;

  // Classification that travels alongside the division.
  typedef struct packed {
    logic [2:0] relation;
    logic       parallel;
  } sic_tag_t;

endpackage

// File: design/sic_products.sv
`timescale 1ns / 1ps

module sic_products import sic_pkg::*; #(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [W-1:0]     ax,
  input  logic signed [W-1:0]     ay,
  input  logic signed [W-1:0]     bx,
  input  logic signed [W-1:0]     by,
  input  logic signed [W-1:0]     cx,
  input  logic signed [W-1:0]     cy,
  input  logic signed [W-1:0]     dx,
  input  logic signed [W-1:0]     dy,
  output logic                    out_valid,
  output logic signed [2*W+2:0]   den,
  output logic signed [3*W+3:0]   mx,
  output logic signed [3*W+3:0]   my,
  output sic_tag_t                tag
);

  localparam int E   = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int K   = W + 2;
  localparam int LPW = 2 * W + 4;
  localparam int NW  = 3 * W + 4;

  logic s1_valid, s2_valid, s3_valid, s4_valid;

  logic signed [E-1:0]   abx1, aby1, cdx1, cdy1, acx1, acy1;
  logic signed [PW-1:0]  p1, p2, p3, p4, p5, p6;
  logic signed [E-1:0]   abx2, aby2, abx3, aby3;
  logic signed [DW-1:0]  den3, na3, nb3, den4;
  logic signed [LPW-1:0] plx, ply;
  logic signed [PW-1:0]  phx, phy;
  sic_tag_t              tag4;

  logic signed [K:0]     na_lo;
  logic signed [E-1:0]   na_hi;
  logic                  ina, inb;
  sic_tag_t              tag_next;

  // Parameter of a crossing lies in the closed unit interval.
  function automatic logic in_unit(input logic signed [DW-1:0] n,
                                   input logic signed [DW-1:0] d);
    logic signed [DW:0] nn;
    logic signed [DW:0] dd;
    nn = d[DW-1] ? -((DW+1)'(n)) : (DW+1)'(n);
    dd = d[DW-1] ? -((DW+1)'(d)) : (DW+1)'(d);
    return !nn[DW] && (nn <= dd);
  endfunction

  // Valid bits advance with the whole pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // Split the first numerator so the scaling multiplies stay narrow, and classify the pair.
  always_comb begin
    na_lo = $signed({1'b0, na3[K-1:0]});
    na_hi = $signed(na3[DW-1:K]);
    ina   = in_unit(na3, den3);
    inb   = in_unit(nb3, den3);
    tag_next.parallel = (den3 == '0);
    if (den3 == '0) begin
      tag_next.relation = (na3 == '0 && nb3 == '0) ? REL_COLLINEAR : REL_PARALLEL;
    end else if (ina && inb) begin
      tag_next.relation = REL_CROSS;
    end else if (inb) begin
      tag_next.relation = REL_FIRST;
    end else if (ina) begin
      tag_next.relation = REL_SECOND;
    end else begin
      tag_next.relation = REL_LINES;
    end
  end

  // Stages one to five: differences, products, determinant, split products, sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      abx1 <= E'(bx) - E'(ax);
      aby1 <= E'(by) - E'(ay);
      cdx1 <= E'(dx) - E'(cx);
      cdy1 <= E'(dy) - E'(cy);
      acx1 <= E'(ax) - E'(cx);
      acy1 <= E'(ay) - E'(cy);

      p1   <= PW'(cdy1) * PW'(abx1);
      p2   <= PW'(cdx1) * PW'(aby1);
      p3   <= PW'(cdx1) * PW'(acy1);
      p4   <= PW'(cdy1) * PW'(acx1);
      p5   <= PW'(acx1) * PW'(aby1);
      p6   <= PW'(acy1) * PW'(abx1);
      abx2 <= abx1;
      aby2 <= aby1;

      den3 <= DW'(p1) - DW'(p2);
      na3  <= DW'(p3) - DW'(p4);
      nb3  <= DW'(p6) - DW'(p5);
      abx3 <= abx2;
      aby3 <= aby2;

      plx  <= LPW'(na_lo) * LPW'(abx3);
      ply  <= LPW'(na_lo) * LPW'(aby3);
      phx  <= PW'(na_hi) * PW'(abx3);
      phy  <= PW'(na_hi) * PW'(aby3);
      den4 <= den3;
      tag4 <= tag_next;

      mx   <= (NW'(phx) <<< K) + NW'(plx);
      my   <= (NW'(phy) <<< K) + NW'(ply);
      den  <= den4;
      tag  <= tag4;
    end
  end

endmodule

// File: design/sic_divider.sv
`timescale 1ns / 1ps

module sic_divider import sic_pkg::*; #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic signed [3*W+3:0] num_x,
  input  logic signed [3*W+3:0] num_y,
  input  logic signed [2*W+2:0] den,
  input  sic_tag_t              in_tag,
  output logic                  out_valid,
  output logic signed [W+2:0]   qx,
  output logic signed [W+2:0]   qy,
  output sic_tag_t              out_tag
);

  localparam int DW = 2 * W + 3;
  localparam int NW = 3 * W + 4;
  localparam int RW = NW + 1;
  localparam int QB = W + 2;
  localparam int NS = W + 2;
  localparam int QW = W + 3;

  // Magnitude stage.
  logic            v0, negx0, negy0;
  logic [NW-1:0]   anx0, any0;
  logic [DW-1:0]   ad0;
  sic_tag_t        tag0;

  // Bit stages: index 0 is the rounded dividend, index NS the last remainder.
  logic            v    [0:NS];
  logic            negx [0:NS];
  logic            negy [0:NS];
  logic [RW-1:0]   remx [0:NS];
  logic [RW-1:0]   remy [0:NS];
  logic [QB-1:0]   qbx  [0:NS];
  logic [QB-1:0]   qby  [0:NS];
  logic [DW-1:0]   ad   [0:NS];
  sic_tag_t        tg   [0:NS];

  logic [QB-1:0]   magx, magy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v[0] <= 1'b0;
    end else if (adv) begin
      v0   <= in_valid;
      v[0] <= v0;
    end
  end

  // Signs and magnitudes, then add half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (adv) begin
      negx0   <= num_x[NW-1] ^ den[DW-1];
      negy0   <= num_y[NW-1] ^ den[DW-1];
      anx0    <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
      any0    <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
      ad0     <= den[DW-1] ? DW'(-den) : DW'(den);
      tag0    <= in_tag;
      remx[0] <= RW'(anx0) + RW'(ad0 >> 1);
      remy[0] <= RW'(any0) + RW'(ad0 >> 1);
      qbx[0]  <= '0;
      qby[0]  <= '0;
      ad[0]   <= ad0;
      negx[0] <= negx0;
      negy[0] <= negy0;
      tg[0]   <= tag0;
    end
  end

  // One quotient bit per stage, most significant first; the top bit flags overflow.
  for (genvar j = 0; j < NS; j++) begin : g_bit
    localparam int B = NS - 1 - j;
    logic [RW-1:0] shx;
    assign shx = RW'(ad[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (adv) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (remx[j] >= shx) begin
          remx[j+1] <= remx[j] - shx;
          qbx[j+1]  <= qbx[j] | (QB'(1) << B);
        end else begin
          remx[j+1] <= remx[j];
          qbx[j+1]  <= qbx[j];
        end
        if (remy[j] >= shx) begin
          remy[j+1] <= remy[j] - shx;
          qby[j+1]  <= qby[j] | (QB'(1) << B);
        end else begin
          remy[j+1] <= remy[j];
          qby[j+1]  <= qby[j];
        end
        ad[j+1]   <= ad[j];
        negx[j+1] <= negx[j];
        negy[j+1] <= negy[j];
        tg[j+1]   <= tg[j];
      end
    end
  end

  // Clip an overflowing quotient, then apply the sign.
  always_comb begin
    magx = qbx[NS][QB-1] ? (QB'(1) << (QB - 1)) : {1'b0, qbx[NS][QB-2:0]};
    magy = qby[NS][QB-1] ? (QB'(1) << (QB - 1)) : {1'b0, qby[NS][QB-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx      <= negx[NS] ? -$signed(QW'(magx)) : $signed(QW'(magx));
      qy      <= negy[NS] ? -$signed(QW'(magy)) : $signed(QW'(magy));
      out_tag <= tg[NS];
    end
  end

endmodule

// File: design/segment_intersection_classifier_unit.sv
`timescale 1ns / 1ps
// Segment intersection classifier.
// The reference segment is loaded through cfg_we / cfg_index / cfg_data
// (0 start x, 1 start y, 2 end x, 3 end y); write it only while idle.
// Each input beat (in_valid / in_ready) carries a tested segment; each
// output beat (out_valid / out_ready) carries relation, cross_x, cross_y.
// The pipeline has five
// stages of differences, products and determinant, two stages of sign
// and rounding set-up, one stage per quotient bit of the divider
// (COORD_WIDTH + 2), one stage of clipping and one of offset and saturation.
// Throughput is one beat per cycle while the receiver does not stall; the quotient bit stages set the depth.
// Reset clears all valid bits and the reference segment to zero.
// When the receiver stalls the whole pipeline holds; in_ready falls
// while a result waits at the output, and nothing is lost or repeated.
module segment_intersection_classifier_unit import sic_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    relation,
  output logic signed [COORD_WIDTH-1:0] cross_x,
  output logic signed [COORD_WIDTH-1:0] cross_y
);

  localparam int W  = COORD_WIDTH;
  localparam int SW = W + 4;

  localparam logic [1:0] IDX_START_X = 2'd0;
  localparam logic [1:0] IDX_START_Y = 2'd1;
  localparam logic [1:0] IDX_END_X   = 2'd2;
  localparam logic [1:0] IDX_END_Y   = 2'd3;

  localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (W - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(2 ** (W - 1));

  logic signed [W-1:0]     ax, ay, bx, by;
  logic                    adv;
  logic                    pv, dv;
  logic signed [2*W+2:0]   den;
  logic signed [3*W+3:0]   mx, my;
  sic_tag_t                ptag, dtag;
  logic signed [W+2:0]     qx, qy;
  logic signed [SW-1:0]    sx, sy;

  // The pipeline moves whenever the output register is free or is being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Reference segment registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
      ay <= '0;
      bx <= '0;
      by <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_START_X: ax <= cfg_data;
        IDX_START_Y: ay <= cfg_data;
        IDX_END_X:   bx <= cfg_data;
        IDX_END_Y:   by <= cfg_data;
        default: ;
      endcase
    end
  end

  sic_products #(.W(W)) u_products (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .ax        (ax),
    .ay        (ay),
    .bx        (bx),
    .by        (by),
    .cx        (seg_start_x),
    .cy        (seg_start_y),
    .dx        (seg_end_x),
    .dy        (seg_end_y),
    .out_valid (pv),
    .den       (den),
    .mx        (mx),
    .my        (my),
    .tag       (ptag)
  );

  sic_divider #(.W(W)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pv),
    .num_x     (mx),
    .num_y     (my),
    .den       (den),
    .in_tag    (ptag),
    .out_valid (dv),
    .qx        (qx),
    .qy        (qy),
    .out_tag   (dtag)
  );

  // Offset from the start point, before saturation.
  assign sx = SW'(qx) + SW'(ax);
  assign sy = SW'(qy) + SW'(ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv;
    end
  end

  // Output register: saturate the point, zero it for parallel pairs.
  always_ff @(posedge clk) begin
    if (adv) begin
      relation <= dtag.relation;
      if (dtag.parallel) begin
        cross_x <= '0;
        cross_y <= '0;
      end else begin
        cross_x <= (sx > SAT_HI) ? W'(SAT_HI) : (sx < SAT_LO) ? W'(SAT_LO) : W'(sx);
        cross_y <= (sy > SAT_HI) ? W'(SAT_HI) : (sy < SAT_LO) ? W'(SAT_LO) : W'(sy);
      end
    end
  end

  // A parallel or collinear result carries no point.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (relation == REL_COLLINEAR || relation == REL_PARALLEL)
      |-> cross_x == '0 && cross_y == '0)
    else $error("point not zero for a parallel result");

  // Only the defined relation codes leave the block.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> relation <= REL_LINES)
    else $error("relation code out of range");

  // A waiting result blocks new input.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
